// ===== design/sha_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha_pkg
// Shared constants, state encoding and the rotate helper for the SHA-256 stream hasher.
// ----------------------------------------------------------------------------
package sha_pkg;

  localparam int unsigned BlockBytes = 64;
  localparam int unsigned Rounds     = 64;

  localparam logic ReqAbsorb = 1'b0;
  localparam logic ReqFinish = 1'b1;

  typedef logic [31:0] word_t;

  localparam word_t InitH [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam word_t RoundK [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  typedef enum logic [5:0] {
    StIdle  = 6'b000001,
    StPad   = 6'b000010,
    StLoad  = 6'b000100,
    StRound = 6'b001000,
    StAdd   = 6'b010000,
    StOut   = 6'b100000
  } state_e;

  function automatic word_t rotr(word_t v, int unsigned n);
    return (v >> n) | (v << (32 - n));
  endfunction

endpackage

// ===== design/sha256_stream_hasher.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha256_stream_hasher
// Byte-streaming SHA-256 with block buffer and chaining value in memories.
// ----------------------------------------------------------------------------
// channel  dir  tdata fields (low bit up)                  tuser
// s_axis   in   data_byte[7:0]                             req_type
// m_axis   out  digest_word0..3 (64 b each, 256 b)         -
//
// An absorb transaction writes its byte to the block buffer; every 64th byte
// adds a compression: loading bytes and chaining words from the memories
// (registered reads), 64 rounds, then the chaining update. A finish writes
// 0x80, pads one byte a cycle to the block end (plus a further block when
// the length does not fit), compresses and hands the digest to the output
// register, waiting only while the previous digest is held. Input is held
// off while busy. Reset restores the chaining value via per-word valid bits.
module sha256_stream_hasher (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [7:0]   s_axis_tdata,   // data_byte[7:0]
  input  logic         s_axis_tuser,   // req_type
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [255:0] m_axis_tdata    // digest_word0, word1, word2, word3 (64 b each)
);

  sha_pkg::state_e state_q, state_d;

  logic [7:0]     buf_mem [sha_pkg::BlockBytes];
  sha_pkg::word_t chain_mem [8];
  logic [7:0]     chain_vld_q;

  logic [6:0]     fill_q;
  logic [60:0]    total_q;
  logic           fin_q;       // finish in progress
  logic           len_q;       // current pad block carries the length
  logic [5:0]     pad_idx_q;
  logic [6:0]     cnt_q;
  sha_pkg::word_t s_q [8];
  sha_pkg::word_t w_q [16];
  logic [255:0]   dig_q;
  logic [255:0]   out_q;
  logic           out_vld_q;
  logic [7:0]     rd_q;
  sha_pkg::word_t ch_rd_q;
  logic [2:0]     ch_addr_q;

  // buffer port
  logic           bw_en;
  logic [5:0]     bw_addr, br_addr;
  logic [7:0]     bw_data;
  // chain port
  logic           cw_en;
  logic [2:0]     cr_addr, cw_addr;
  sha_pkg::word_t cw_data, ch_val;

  logic           in_acc, out_acc, out_free, absorb;
  logic [63:0]    bits;
  logic [7:0]     pad_byte;
  sha_pkg::word_t t1, t2, wn;

  assign in_acc   = s_axis_tvalid && s_axis_tready;
  assign out_acc  = m_axis_tvalid && m_axis_tready;
  assign out_free = !out_vld_q || m_axis_tready;
  assign absorb   = (s_axis_tuser == sha_pkg::ReqAbsorb);
  assign bits     = {total_q, 3'b000};

  assign s_axis_tready = (state_q == sha_pkg::StIdle);
  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_q;

  // pad byte at position pad_idx_q
  always_comb begin
    pad_byte = 8'h00;
    if (len_q && (pad_idx_q >= 6'd56)) begin
      pad_byte = bits[{3'd7 - pad_idx_q[2:0], 3'b000} +: 8];
    end
  end

  always_ff @(posedge clk_i) begin
    if (bw_en) buf_mem[bw_addr] <= bw_data;
    rd_q <= buf_mem[br_addr];
  end

  always_ff @(posedge clk_i) begin
    if (cw_en) chain_mem[cw_addr] <= cw_data;
    ch_rd_q   <= chain_mem[cr_addr];
    ch_addr_q <= cr_addr;
  end
  assign ch_val = chain_vld_q[ch_addr_q] ? ch_rd_q : sha_pkg::InitH[ch_addr_q];

  // round datapath
  always_comb begin
    t1 = s_q[7] + (sha_pkg::rotr(s_q[4], 6) ^ sha_pkg::rotr(s_q[4], 11) ^
         sha_pkg::rotr(s_q[4], 25)) + ((s_q[4] & s_q[5]) ^ (~s_q[4] & s_q[6])) +
         sha_pkg::RoundK[cnt_q[5:0]] + w_q[0];
    t2 = (sha_pkg::rotr(s_q[0], 2) ^ sha_pkg::rotr(s_q[0], 13) ^
         sha_pkg::rotr(s_q[0], 22)) +
         ((s_q[0] & s_q[1]) ^ (s_q[0] & s_q[2]) ^ (s_q[1] & s_q[2]));
    wn = w_q[0] + (sha_pkg::rotr(w_q[1], 7) ^ sha_pkg::rotr(w_q[1], 18) ^ (w_q[1] >> 3))
         + w_q[9] + (sha_pkg::rotr(w_q[14], 17) ^ sha_pkg::rotr(w_q[14], 19) ^
         (w_q[14] >> 10));
  end

  always_comb begin
    state_d = state_q;
    bw_en   = 1'b0;
    bw_addr = fill_q[5:0];
    bw_data = s_axis_tdata;
    br_addr = cnt_q[5:0];
    cr_addr = cnt_q[2:0];
    cw_en   = 1'b0;
    cw_addr = ch_addr_q;
    cw_data = ch_val + s_q[0];
    case (state_q)
      sha_pkg::StIdle: begin
        if (in_acc) begin
          bw_en = 1'b1;
          if (!absorb) bw_data = 8'h80;
          if (fill_q == 7'd63) state_d = sha_pkg::StLoad;
          else if (!absorb) state_d = sha_pkg::StPad;
        end
      end
      sha_pkg::StPad: begin
        bw_en   = 1'b1;
        bw_addr = pad_idx_q;
        bw_data = pad_byte;
        if (pad_idx_q == 6'd63) state_d = sha_pkg::StLoad;
      end
      sha_pkg::StLoad: begin
        if (cnt_q == 7'd64) state_d = sha_pkg::StRound;
      end
      sha_pkg::StRound: begin
        if (cnt_q == 7'd63) state_d = sha_pkg::StAdd;
      end
      sha_pkg::StAdd: begin
        cw_en = (cnt_q != 7'd0);
        if (cnt_q == 7'd8) begin
          if (!fin_q) state_d = sha_pkg::StIdle;
          else if (!len_q) state_d = sha_pkg::StPad;
          else state_d = sha_pkg::StOut;
        end
      end
      sha_pkg::StOut: begin
        if (out_free) state_d = sha_pkg::StIdle;
      end
      default: state_d = sha_pkg::StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= sha_pkg::StIdle;
      fill_q <= '0; total_q <= '0; fin_q <= 1'b0; len_q <= 1'b0;
      pad_idx_q <= '0; cnt_q <= '0; chain_vld_q <= '0; out_vld_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if ((state_q == sha_pkg::StOut) && out_free) out_vld_q <= 1'b1;
      else if (out_acc) out_vld_q <= 1'b0;
      case (state_q)
        sha_pkg::StIdle: begin
          cnt_q <= '0;
          if (in_acc && absorb) begin
            total_q <= total_q + 61'd1;
            fill_q  <= (fill_q == 7'd63) ? 7'd0 : fill_q + 7'd1;
          end else if (in_acc) begin
            fin_q     <= 1'b1;
            len_q     <= (fill_q < 7'd56);
            pad_idx_q <= fill_q[5:0] + 6'd1;
            fill_q    <= '0;
          end
        end
        sha_pkg::StPad: pad_idx_q <= pad_idx_q + 6'd1;
        sha_pkg::StLoad: cnt_q <= (cnt_q == 7'd64) ? 7'd0 : cnt_q + 7'd1;
        sha_pkg::StRound: cnt_q <= (cnt_q == 7'd63) ? 7'd0 : cnt_q + 7'd1;
        sha_pkg::StAdd: begin
          if (cnt_q == 7'd8) begin
            cnt_q <= '0;
            if (fin_q && len_q) begin
              chain_vld_q <= '0;
              fin_q       <= 1'b0;
              len_q       <= 1'b0;
              total_q     <= '0;
            end else begin
              chain_vld_q <= 8'hff;
              if (fin_q) begin
                len_q     <= 1'b1;
                pad_idx_q <= '0;
              end
            end
          end else begin
            cnt_q <= cnt_q + 7'd1;
          end
        end
        default: ;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      sha_pkg::StLoad: begin
        if (cnt_q != 7'd0) begin
          if (cnt_q[1:0] == 2'd1) begin
            for (int i = 0; i < 15; i++) w_q[i] <= w_q[i+1];
          end
          w_q[15] <= {w_q[15][23:0], rd_q};
        end
        if ((cnt_q >= 7'd1) && (cnt_q <= 7'd8)) begin
          for (int i = 0; i < 7; i++) s_q[i] <= s_q[i+1];
          s_q[7] <= ch_val;
        end
      end
      sha_pkg::StRound: begin
        s_q[7] <= s_q[6]; s_q[6] <= s_q[5]; s_q[5] <= s_q[4];
        s_q[4] <= s_q[3] + t1;
        s_q[3] <= s_q[2]; s_q[2] <= s_q[1]; s_q[1] <= s_q[0];
        s_q[0] <= t1 + t2;
        for (int i = 0; i < 15; i++) w_q[i] <= w_q[i+1];
        w_q[15] <= wn;
      end
      sha_pkg::StAdd: begin
        if (cnt_q != 7'd0) begin
          for (int i = 0; i < 7; i++) s_q[i] <= s_q[i+1];
          s_q[7] <= s_q[0];
          dig_q  <= {cw_data, dig_q[255:32]};
        end
      end
      sha_pkg::StOut: begin
        if (out_free) begin
          out_q <= {dig_q[223:192], dig_q[255:224], dig_q[159:128], dig_q[191:160],
                    dig_q[95:64], dig_q[127:96], dig_q[31:0], dig_q[63:32]};
        end
      end
      default: ;
    endcase
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("digest changed while stalled");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(state_q))
    else $error("state not one-hot");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !fill_q[6])
    else $error("fill count out of range");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready |-> !fin_q)
    else $error("input ready during finish");

endmodule
